>>> sv/egcd_pkg.sv
// Shared constants for the extended GCD block.
package egcd_pkg;

   // Default operand width handed to the datapath.
   localparam int OPERAND_WIDTH_DEFAULT = 31;

   // Fixed widths of the request and response fields.
   localparam int IN_WIDTH   = 31;
   localparam int GCD_WIDTH  = 31;
   localparam int COEF_WIDTH = 32;

endpackage

>>> sv/egcd_divider.sv
// Iterative restoring divider with shift-add products of the quotient and two coefficients.
module egcd_divider #(
   parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [OPERAND_WIDTH-1:0]         dividend,
   input  logic [OPERAND_WIDTH-1:0]         divisor,
   input  logic [egcd_pkg::COEF_WIDTH-1:0]  mul_s,
   input  logic [egcd_pkg::COEF_WIDTH-1:0]  mul_t,
   output logic                             done,
   output logic [OPERAND_WIDTH-1:0]         remainder,
   output logic [egcd_pkg::COEF_WIDTH-1:0]  prod_s,
   output logic [egcd_pkg::COEF_WIDTH-1:0]  prod_t
);

   localparam int CntW  = $clog2(OPERAND_WIDTH + 1);
   localparam int CoefW = egcd_pkg::COEF_WIDTH;

   logic                     active_ff, active_in;
   logic                     done_ff, done_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] num_ff, num_in;
   logic [CoefW-1:0]         acc_s_ff, acc_s_in;
   logic [CoefW-1:0]         acc_t_ff, acc_t_in;

   logic [OPERAND_WIDTH:0]   trial;
   logic [OPERAND_WIDTH:0]   diff;
   logic                     q_bit;

   // One quotient bit per cycle, most significant first.
   assign trial = {rem_ff, num_ff[OPERAND_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign q_bit = (trial >= {1'b0, divisor});

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      acc_s_in  = acc_s_ff;
      acc_t_in  = acc_t_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CntW'(OPERAND_WIDTH);
         rem_in    = '0;
         num_in    = dividend;
         acc_s_in  = '0;
         acc_t_in  = '0;
      end else if (active_ff) begin
         rem_in   = q_bit ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
         num_in   = {num_ff[OPERAND_WIDTH-2:0], 1'b0};
         // The products accumulate modulo the coefficient width, as the quotient bits arrive.
         acc_s_in = {acc_s_ff[CoefW-2:0], 1'b0} + (q_bit ? mul_s : '0);
         acc_t_in = {acc_t_ff[CoefW-2:0], 1'b0} + (q_bit ? mul_t : '0);
         cnt_in   = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      acc_s_ff <= acc_s_in;
      acc_t_ff <= acc_t_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign prod_s    = acc_s_ff;
   assign prod_t    = acc_t_ff;

endmodule

>>> sv/extended_gcd.sv
// Top level of the extended GCD block: sequencer, remainder and coefficient registers.
//
// Usage: drive req_a_value and req_b_value and raise start while busy is low; the
// operands are transferred at that clock edge and busy rises in the next cycle.
// The block then runs the extended Euclidean algorithm and, once done, pulses
// rsp_valid for exactly one cycle with rsp_gcd_value, rsp_coef_x and rsp_coef_y,
// where gcd = a*x + b*y. The response transfer happens at the edge that ends that
// cycle; the receiver cannot stall it, so the results must be captured then.
// Each quotient step passes through the check state and then the bit-serial
// divider, one quotient bit per cycle. When b is zero the check state responds at
// once, without starting the divider.
// Only one item is in flight; busy stays low from the cycle rsp_valid is high, so
// a new start may be given in the same cycle as the response.
// Reset is synchronous and active high: it returns the sequencer to idle and
// drops busy and rsp_valid; an item in flight is abandoned.
module extended_gcd #(
   parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [egcd_pkg::IN_WIDTH-1:0]          req_a_value,
   input  logic [egcd_pkg::IN_WIDTH-1:0]          req_b_value,
   output logic                                   busy,
   output logic                                   rsp_valid,
   output logic [egcd_pkg::GCD_WIDTH-1:0]         rsp_gcd_value,
   output logic signed [egcd_pkg::COEF_WIDTH-1:0] rsp_coef_x,
   output logic signed [egcd_pkg::COEF_WIDTH-1:0] rsp_coef_y
);

   localparam int CoefW = egcd_pkg::COEF_WIDTH;
   localparam int GcdW  = egcd_pkg::GCD_WIDTH;

   // Sequencer states.
   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StCheck = 2'd1;
   localparam logic [1:0] StDiv   = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [OPERAND_WIDTH-1:0] r_prev_ff, r_prev_in;
   logic [OPERAND_WIDTH-1:0] r_cur_ff, r_cur_in;
   logic [CoefW-1:0]         s_prev_ff, s_prev_in;
   logic [CoefW-1:0]         s_cur_ff, s_cur_in;
   logic [CoefW-1:0]         t_prev_ff, t_prev_in;
   logic [CoefW-1:0]         t_cur_ff, t_cur_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GcdW-1:0]          gcd_ff, gcd_in;
   logic [CoefW-1:0]         coef_x_ff, coef_x_in;
   logic [CoefW-1:0]         coef_y_ff, coef_y_in;

   logic                     accept;
   logic                     div_start;
   logic                     div_done;
   logic [OPERAND_WIDTH-1:0] div_rem;
   logic [CoefW-1:0]         prod_s;
   logic [CoefW-1:0]         prod_t;

   assign busy   = (state_ff != StIdle);
   assign accept = start && !busy;

   // The shared divider produces the remainder r_prev mod r_cur and, alongside,
   // the low coefficient bits of q*s_cur and q*t_cur. Coefficients are kept
   // modulo 2^32; only their low 32 bits are ever reported, so that is exact.
   egcd_divider #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (r_prev_ff),
      .divisor  (r_cur_ff),
      .mul_s    (s_cur_ff),
      .mul_t    (t_cur_ff),
      .done     (div_done),
      .remainder(div_rem),
      .prod_s   (prod_s),
      .prod_t   (prod_t)
   );

   always_comb begin
      state_in     = state_ff;
      r_prev_in    = r_prev_ff;
      r_cur_in     = r_cur_ff;
      s_prev_in    = s_prev_ff;
      s_cur_in     = s_cur_ff;
      t_prev_in    = t_prev_ff;
      t_cur_in     = t_cur_ff;
      rsp_valid_in = 1'b0;
      gcd_in       = gcd_ff;
      coef_x_in    = coef_x_ff;
      coef_y_in    = coef_y_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               // Operands are truncated or zero-extended to the datapath width.
               r_prev_in = OPERAND_WIDTH'(req_a_value);
               r_cur_in  = OPERAND_WIDTH'(req_b_value);
               s_prev_in = CoefW'(1);
               s_cur_in  = '0;
               t_prev_in = '0;
               t_cur_in  = CoefW'(1);
               state_in  = StCheck;
            end
         end
         StCheck: begin
            if (r_cur_ff == '0) begin
               // The last non-zero remainder is the gcd; a zero b lands here at once.
               rsp_valid_in = 1'b1;
               gcd_in       = GcdW'(r_prev_ff);
               coef_x_in    = s_prev_ff;
               coef_y_in    = t_prev_ff;
               state_in     = StIdle;
            end else begin
               div_start = 1'b1;
               state_in  = StDiv;
            end
         end
         StDiv: begin
            if (div_done) begin
               r_prev_in = r_cur_ff;
               r_cur_in  = div_rem;
               s_prev_in = s_cur_ff;
               s_cur_in  = s_prev_ff - prod_s;
               t_prev_in = t_cur_ff;
               t_cur_in  = t_prev_ff - prod_t;
               state_in  = StCheck;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_prev_ff <= r_prev_in;
      r_cur_ff  <= r_cur_in;
      s_prev_ff <= s_prev_in;
      s_cur_ff  <= s_cur_in;
      t_prev_ff <= t_prev_in;
      t_cur_ff  <= t_cur_in;
      gcd_ff    <= gcd_in;
      coef_x_ff <= coef_x_in;
      coef_y_ff <= coef_y_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gcd_value = gcd_ff;
   assign rsp_coef_x    = $signed(coef_x_ff);
   assign rsp_coef_y    = $signed(coef_y_ff);

`ifndef ASSERT_OFF
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while the sequencer is still busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == StDiv))
      else $error("divider finished outside the divide state");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == StCheck))
      else $error("accepted request did not enter the check state");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StCheck) && (r_cur_ff == '0) |=> rsp_valid)
      else $error("zero remainder did not produce a response");

   a_div_start_once: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_start && (state_ff == StDiv))
      else $error("divider restarted while a division runs");
`endif

endmodule
